/* hw/rtl/pal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg
// Shared operation codes, status codes and the command that the list
// controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;
  localparam int unsigned DataW   = 32;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT   = 3'd0,
    FUNC_REMOVE   = 3'd1,
    FUNC_REPLACE  = 3'd2,
    FUNC_RETRIEVE = 3'd3,
    FUNC_CLEAR    = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic            shift_up;
    logic            shift_down;
    logic            write;
    logic [PosW-1:0] pos;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/pal_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Loads the new word, its left neighbor on insert or its
// right neighbor on remove, depending on where it sits relative to the
// addressed position. Drives its word onto the read tap when addressed.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int INDEX     = 0,
  parameter int WORD_BITS = 32
) (
  input  wire                    clk_i,
  input  wire pal_pkg::cell_cmd_t cmd_i,
  input  wire  [WORD_BITS-1:0]   value_i,
  input  wire  [WORD_BITS-1:0]   left_i,
  input  wire  [WORD_BITS-1:0]   right_i,
  output logic [WORD_BITS-1:0]   word_o,
  output logic [WORD_BITS-1:0]   tap_o
);
  import pal_pkg::*;

  logic                 hit;
  logic                 above;
  logic [WORD_BITS-1:0] word_q;
  logic [WORD_BITS-1:0] word_d;

  assign hit   = (int'(cmd_i.pos) == INDEX);
  assign above = (int'(cmd_i.pos) < INDEX);

  always_comb begin
    word_d = word_q;
    if (cmd_i.shift_up) begin
      if (hit) begin
        word_d = value_i;
      end else if (above) begin
        word_d = left_i;
      end
    end else if (cmd_i.shift_down) begin
      // the addressed slot and everything past it move down one place
      if (hit || above) begin
        word_d = right_i;
      end
    end else if (cmd_i.write && hit) begin
      word_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = hit ? word_q : '0;

endmodule
`default_nettype wire

/* hw/rtl/pal_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pal_ctrl
// Fill count and request decode. Checks each request against the count,
// issues the shift or write command to the cells and registers the result.
// ----------------------------------------------------------------------------
module pal_ctrl #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              fire_i,
  input  wire  [pal_pkg::FuncW-1:0]        func_i,
  input  wire  [pal_pkg::PosW-1:0]         position_i,
  input  wire  [WORD_BITS-1:0]             rd_word_i,
  output pal_pkg::cell_cmd_t               cmd_o,
  output logic                             done_o,
  output logic [pal_pkg::StatusW-1:0]      status_o,
  output logic [pal_pkg::DataW-1:0]        read_value_o,
  output logic [pal_pkg::CountW-1:0]       fill_count_o,
  output logic                             is_full_o,
  output logic                             is_empty_o
);
  import pal_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > int'(PosW)) ? CntW : int'(PosW);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  status_e         status_q, status_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            full, empty, below, not_above, rd_sel;

  assign pos_ext   = CmpW'(position_i);
  assign cnt_ext   = CmpW'(cnt_q);
  assign full      = (cnt_q == CntW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign below     = (pos_ext < cnt_ext);
  assign not_above = (pos_ext <= cnt_ext);

  always_comb begin
    cmd_o            = '0;
    cmd_o.pos        = position_i;
    cnt_d            = cnt_q;
    status_d         = ST_OK;
    rd_sel           = 1'b0;
    if (fire_i) begin
      unique case (func_i)
        FUNC_INSERT: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else if (!not_above) begin
            status_d = ST_RANGE;
          end else begin
            cmd_o.shift_up = 1'b1;
            cnt_d          = cnt_q + CntW'(1);
          end
        end
        FUNC_REMOVE: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else if (!below) begin
            status_d = ST_RANGE;
          end else begin
            cmd_o.shift_down = 1'b1;
            rd_sel           = 1'b1;
            cnt_d            = cnt_q - CntW'(1);
          end
        end
        FUNC_REPLACE: begin
          if (!below) begin
            status_d = ST_RANGE;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
        FUNC_RETRIEVE: begin
          if (!below) begin
            status_d = ST_RANGE;
          end else begin
            rd_sel = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          cnt_d = '0;
        end
        default: begin
          status_d = ST_RANGE;
        end
      endcase
    end
  end

  assign rd_d = rd_sel ? DataW'(rd_word_i) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rd_q     <= rd_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rd_q;
  assign fill_count_o = CountW'(cnt_q);
  assign is_full_o    = full;
  assign is_empty_o   = empty;

endmodule
`default_nettype wire

/* hw/rtl/positional_array_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to DEPTH words held in a row of cells, with insert,
// remove, replace, retrieve and clear at a list position.
// result strobe done_o is registered and rises in the cycle after the request is taken
// throughput: one request per cycle; busy stays low, since every cell shifts
//   or loads in the same cycle the request is decoded
// results cannot be stalled and appear for exactly one cycle
// reset clears the fill count and the strobe; slot contents are left as is
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire  [pal_pkg::FuncW-1:0]        func_i,
  input  wire  [pal_pkg::PosW-1:0]         position_i,
  input  wire  [pal_pkg::DataW-1:0]        entry_value_i,
  output logic                             done_o,
  output logic [pal_pkg::StatusW-1:0]      status_o,
  output logic [pal_pkg::DataW-1:0]        read_value_o,
  output logic [pal_pkg::CountW-1:0]       fill_count_o,
  output logic                             is_full_o,
  output logic                             is_empty_o
);
  import pal_pkg::*;

  cell_cmd_t            cmd;
  logic                 fire;
  logic [WORD_BITS-1:0] value;
  logic [WORD_BITS-1:0] words [DEPTH];
  logic [WORD_BITS-1:0] taps  [DEPTH];
  logic [WORD_BITS-1:0] rd_word;

  assign busy  = 1'b0;
  assign fire  = start && !busy;
  assign value = WORD_BITS'(entry_value_i);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = words[i+1];
    end
    pal_cell #(
      .INDEX     (i),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .word_o  (words[i]),
      .tap_o   (taps[i])
    );
  end

  // at most one cell drives its tap
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | taps[i];
    end
  end

  pal_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .func_i       (func_i),
    .position_i   (position_i),
    .rd_word_i    (rd_word),
    .cmd_o        (cmd),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .fill_count_o (fill_count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

endmodule
`default_nettype wire

/* dv/positional_array_list_tb.sv */
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Drives insert, remove, replace, retrieve, clear and undefined function
// requests into the list. A behavioral copy of the list predicts each
// result, and every done_o strobe is checked field by field against it.
// ----------------------------------------------------------------------------
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int RAND_REQS = 1900;
  localparam logic [FuncW-1:0] FUNC_UNDEF = 3'd7;

  typedef struct {
    logic [FuncW-1:0] func;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
    int unsigned      gap;
    bit               hold;
  } list_req_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   rd;
    logic [CountW-1:0]  count;
    logic               full;
    logic               empty;
  } list_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic [FuncW-1:0]    req_func = '0;
  logic [PosW-1:0]     req_pos = '0;
  logic [DataW-1:0]    req_value = '0;
  logic                busy;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [DataW-1:0]    read_value_o;
  logic [CountW-1:0]   fill_count_o;
  logic                is_full_o;
  logic                is_empty_o;

  list_req_t           req_q[$];
  list_rsp_t           rsp_q[$];
  logic                req_taken = 1'b0;
  int unsigned         mismatch_cnt = 0;
  int                  gen_cnt = 0;

  // shadow copy of the list
  logic [WORD_BITS-1:0] shadow_slots [DEPTH];
  int                   shadow_used = 0;

  positional_array_list #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (req_func),
    .position_i   (req_pos),
    .entry_value_i(req_value),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .fill_count_o (fill_count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic list_rsp_t apply_list_op(logic [FuncW-1:0] func, logic [PosW-1:0] pos,
                                              logic [DataW-1:0] value);
    list_rsp_t rsp;
    int        p;
    p          = int'(pos);
    rsp.status = ST_OK;
    rsp.rd     = '0;
    case (func)
      FUNC_INSERT: begin
        if (shadow_used >= DEPTH) rsp.status = ST_OVERFLOW;
        else if (p > shadow_used) rsp.status = ST_RANGE;
        else begin
          for (int i = shadow_used; i > p; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[p] = value[WORD_BITS-1:0];
          shadow_used++;
        end
      end
      FUNC_REMOVE: begin
        if (shadow_used == 0) rsp.status = ST_UNDERFLOW;
        else if (p >= shadow_used) rsp.status = ST_RANGE;
        else begin
          rsp.rd = DataW'(shadow_slots[p]);
          for (int i = p; i + 1 < shadow_used; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_used--;
        end
      end
      FUNC_REPLACE: begin
        if (p >= shadow_used) rsp.status = ST_RANGE;
        else shadow_slots[p] = value[WORD_BITS-1:0];
      end
      FUNC_RETRIEVE: begin
        if (p >= shadow_used) rsp.status = ST_RANGE;
        else rsp.rd = DataW'(shadow_slots[p]);
      end
      FUNC_CLEAR: shadow_used = 0;
      default: rsp.status = ST_RANGE;
    endcase
    rsp.count = CountW'(shadow_used);
    rsp.full  = (shadow_used == DEPTH);
    rsp.empty = (shadow_used == 0);
    return rsp;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // queue a request and track the fill count so positions stay mostly useful
  task automatic add_req(logic [FuncW-1:0] func, logic [PosW-1:0] pos, logic [DataW-1:0] value,
                         int unsigned gap = 0, bit hold = 1'b0);
    list_req_t r;
    r = '{func: func, pos: pos, value: value, gap: gap, hold: hold};
    req_q.push_back(r);
    case (func)
      FUNC_INSERT: if (gen_cnt < DEPTH && int'(pos) <= gen_cnt) gen_cnt++;
      FUNC_REMOVE: if (gen_cnt != 0 && int'(pos) < gen_cnt) gen_cnt--;
      FUNC_CLEAR:  gen_cnt = 0;
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !req_taken) begin
        // request not taken yet, keep it up
      end else if (req_q.size() != 0 && req_q[0].gap != 0) begin
        req_q[0].gap = req_q[0].gap - 1;
        start <= 1'b0;
      end else if (req_q.size() != 0 && (!req_q[0].hold || rsp_q.size() == 0)) begin
        req_func  <= req_q[0].func;
        req_pos   <= req_q[0].pos;
        req_value <= req_q[0].value;
        start     <= 1'b1;
        void'(req_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (rsp_q.size() == 0) begin
          $display("%0t unexpected result: status %0d read %0h count %0d", $time,
                   status_o, read_value_o, fill_count_o);
          mismatch_cnt++;
        end else begin
          want = rsp_q.pop_front();
          check_field("status", DataW'(want.status), DataW'(status_o));
          check_field("read_value", want.rd, read_value_o);
          check_field("fill_count", DataW'(want.count), DataW'(fill_count_o));
          check_field("is_full", DataW'(want.full), DataW'(is_full_o));
          check_field("is_empty", DataW'(want.empty), DataW'(is_empty_o));
        end
      end
      if (start && !busy) rsp_q.push_back(apply_list_op(req_func, req_pos, req_value));
      req_taken <= start && !busy;
    end else begin
      req_taken <= 1'b0;
    end
  end

  initial begin
    logic [FuncW-1:0] f;
    logic [PosW-1:0]  p;
    logic [DataW-1:0] v;
    int unsigned      roll;
    int unsigned      gap;
    int               mode;
    int               burst_len;
    bit               gappy;
    int               n_rand;

    // directed: empty-list errors, undefined code, shifting at both ends
    add_req(FUNC_REMOVE, 5'd0, 32'h0);
    add_req(FUNC_RETRIEVE, 5'd0, 32'h0);
    add_req(FUNC_REPLACE, 5'd0, 32'hFFFF_FFFF);
    add_req(FUNC_UNDEF, 5'd31, 32'hFFFF_FFFF);
    add_req(FUNC_INSERT, 5'd1, 32'h1234_5678);
    add_req(FUNC_INSERT, 5'd0, 32'h0000_0000);
    add_req(FUNC_INSERT, 5'd0, 32'hFFFF_FFFF);
    add_req(FUNC_INSERT, 5'd2, 32'hA5A5_5A5A);
    add_req(FUNC_REPLACE, 5'd1, 32'h8000_0001);
    add_req(FUNC_RETRIEVE, 5'd1, 32'h0);
    add_req(FUNC_REMOVE, 5'd3, 32'h0);
    add_req(FUNC_REMOVE, 5'd0, 32'h0);
    add_req(FUNC_INSERT, 5'd31, 32'h0);
    add_req(FUNC_CLEAR, 5'd0, 32'h0, 0, 1'b1);
    // fill to the top, then overflow and remove at the last slot
    for (int i = 0; i < DEPTH; i++) add_req(FUNC_INSERT, 5'($urandom_range(0, i)), $urandom);
    add_req(FUNC_INSERT, 5'd0, 32'hDEAD_BEEF);
    add_req(FUNC_REMOVE, 5'd15, 32'h0);
    add_req(FUNC_RETRIEVE, 5'd15, 32'h0);

    n_rand = 0;
    while (n_rand < RAND_REQS) begin
      mode      = $urandom_range(0, 2);
      burst_len = $urandom_range(20, 60);
      gappy     = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < burst_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) f = FuncW'($urandom_range(5, 7));
        else if (roll < 3) f = FUNC_CLEAR;
        else begin
          roll = $urandom_range(0, 99);
          case (mode)
            0:       f = roll < 60 ? FUNC_INSERT : roll < 75 ? FUNC_REMOVE :
                         roll < 88 ? FUNC_REPLACE : FUNC_RETRIEVE;
            1:       f = roll < 15 ? FUNC_INSERT : roll < 70 ? FUNC_REMOVE :
                         roll < 85 ? FUNC_REPLACE : FUNC_RETRIEVE;
            default: f = roll < 30 ? FUNC_INSERT : roll < 55 ? FUNC_REMOVE :
                         roll < 78 ? FUNC_REPLACE : FUNC_RETRIEVE;
          endcase
        end
        if ($urandom_range(0, 9) == 0) p = PosW'($urandom_range(0, 31));
        else p = PosW'($urandom_range(0, gen_cnt));
        roll = $urandom_range(0, 99);
        v = roll < 10 ? '0 : roll < 20 ? '1 : DataW'($urandom);
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (gappy) gap = roll < 70 ? 0 : roll < 95 ? $urandom_range(1, 3) : $urandom_range(8, 40);
        add_req(f, p, v, gap, k == 0 && $urandom_range(0, 5) == 0);
        n_rand++;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || start || rsp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* positional_array_list.f */
hw/rtl/pal_pkg.sv
hw/rtl/pal_cell.sv
hw/rtl/pal_ctrl.sv
hw/rtl/positional_array_list.sv
dv/positional_array_list_tb.sv
